[hw/rtl/gbcf_pkg.sv]
// types and constants shared by the box collision filter
// no dependencies

package gbcf_pkg;

  localparam int COORD_W = 20;
  localparam int SIZE_W  = 16;
  localparam int EDGE_W  = 21;
  localparam int INDEX_W = 16;

  typedef logic signed [EDGE_W-1:0] edge_t;

  typedef struct packed {
    edge_t left;
    edge_t top;
    edge_t right;
    edge_t bottom;
  } box_t;

  // token walking down the cell chain
  typedef struct packed {
    logic vld;
    logic empty;
    logic hit;
    box_t box;
  } tok_t;

  // broadcast write into the table
  typedef struct packed {
    logic en;
    logic empty;
    box_t box;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

[hw/rtl/gbcf_in_if.sv]
// input channel of the box collision filter: valid, ready and box fields
// depends on gbcf_pkg

interface gbcf_in_if
  import gbcf_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      first_of_set;
  logic signed [COORD_W-1:0] box_left;
  logic signed [COORD_W-1:0] box_top;
  logic [SIZE_W-1:0]         box_width;
  logic [SIZE_W-1:0]         box_height;

  modport source (
    output valid, first_of_set, box_left, box_top, box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, first_of_set, box_left, box_top, box_width, box_height,
    output ready
  );
endinterface

[hw/rtl/gbcf_out_if.sv]
// result channel of the box collision filter: valid, ready and verdict fields
// depends on gbcf_pkg

interface gbcf_out_if
  import gbcf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [INDEX_W-1:0] box_index;
  logic               table_full;

  modport source (
    output valid, accepted, box_index, table_full,
    input  ready
  );
  modport sink (
    input  valid, accepted, box_index, table_full,
    output ready
  );
endinterface

[hw/rtl/gbcf_cell.sv]
// one table entry of the collision chain: holds a stored box and tests the passing token
// depends on gbcf_pkg

module gbcf_cell
  import gbcf_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  input  logic [CNT_W-1:0] count,
  input  wr_t              wr,
  input  logic [CNT_W-1:0] wr_sel
);

  box_t entry;
  logic entry_empty;
  logic live;
  logic overlap;

  // entry written when the controller appends at this position
  always_ff @(posedge clk) begin
    if (wr.en && (wr_sel == CNT_W'(IDX))) begin
      entry       <= wr.box;
      entry_empty <= wr.empty;
    end
  end

  assign live = (CNT_W'(IDX) < count) && !entry_empty && !tok_in.empty;

  // open interiors overlap
  assign overlap = (tok_in.box.left < entry.right) && (entry.left < tok_in.box.right) &&
                   (tok_in.box.top < entry.bottom) && (entry.top < tok_in.box.bottom);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.empty <= tok_in.empty;
    tok_out.box   <= tok_in.box;
    tok_out.hit   <= tok_in.hit || (live && overlap);
  end

endmodule

[hw/rtl/greedy_box_collision_filter.sv]
// greedy box collision filter: top level with controller and cell chain
// depends on gbcf_pkg, gbcf_in_if, gbcf_out_if and gbcf_cell
//
// usage
//   boxes   : one transfer per box (first_of_set, left, top, width, height)
//   results : one transfer per box (accepted, box_index, table_full)
// a box is taken into a head register and then walks down a chain of
// MAX_BOXES cells, one cell per cycle; each cell below the fill count holds
// one accepted box and marks the token if the interiors overlap. when the
// token leaves the last cell the controller appends the box at the fill
// position (if it is clear and there is room) and loads the result register.
// on its way to results.valid a box passes the head register, the cell chain,
// the parking register and the result register; a new box is taken only once
// the last one has reached the result register, so one box is in flight at a time
// the next box is taken while a result still waits in the output register;
// if the receiver stalls, the following box waits at the end of the chain
// and the table is not touched until its result can be loaded
// reset: fill count and box numbering cleared, chain emptied, no result
// pending; table contents are left as they are and are never read before
// they are written

module greedy_box_collision_filter
  import gbcf_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input logic clk,
  input logic rst,
  gbcf_in_if.sink    boxes,
  gbcf_out_if.source results
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  state_t             state;
  state_t             state_next;
  tok_t               head;
  tok_t               chain [0:MAX_BOXES];
  tok_t               done;
  logic [CNT_W-1:0]   count;
  logic [INDEX_W-1:0] next_index;
  logic [INDEX_W-1:0] item_index;
  wr_t                wr;
  logic               take;
  logic               fin_go;
  logic               fits;
  logic               out_vld;
  logic               out_accepted;
  logic               out_table_full;
  logic [INDEX_W-1:0] out_index;
  edge_t              in_left;
  edge_t              in_top;

  // sign-extended edges of the incoming box
  assign in_left = {boxes.box_left[COORD_W-1], boxes.box_left};
  assign in_top  = {boxes.box_top[COORD_W-1], boxes.box_top};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next  = state;
    boxes.ready = 1'b0;
    fin_go      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        boxes.ready = 1'b1;
        if (boxes.valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[MAX_BOXES].vld) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the result register to free up
        fin_go = !out_vld || results.ready;
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign take = boxes.valid && boxes.ready;

  // head of the chain: right and bottom edges are exact 21-bit sums
  always_ff @(posedge clk) begin
    if (rst) begin
      head.vld <= 1'b0;
    end else begin
      head.vld <= take;
    end
    if (take) begin
      head.box.left   <= in_left;
      head.box.top    <= in_top;
      head.box.right  <= in_left + $signed({{(EDGE_W-SIZE_W){1'b0}}, boxes.box_width});
      head.box.bottom <= in_top + $signed({{(EDGE_W-SIZE_W){1'b0}}, boxes.box_height});
      head.empty      <= (boxes.box_width == '0) || (boxes.box_height == '0);
      head.hit        <= 1'b0;
    end
  end

  assign chain[0] = head;

  // row of table cells
  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    gbcf_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1]),
      .count   (count),
      .wr      (wr),
      .wr_sel  (count)
    );
  end

  // token leaving the chain is parked until the result can be loaded
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && chain[MAX_BOXES].vld) begin
      done <= chain[MAX_BOXES];
    end
  end

  assign fits = !done.hit && (count < CNT_W'(MAX_BOXES));

  // append into the table at the fill position
  always_comb begin
    wr.en    = fin_go && fits;
    wr.empty = done.empty;
    wr.box   = done.box;
  end

  // fill count and box numbering; a new set restarts both before the box
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      next_index <= '0;
    end else if (take) begin
      if (boxes.first_of_set) begin
        count      <= '0;
        next_index <= INDEX_W'(1);
      end else begin
        next_index <= next_index + 1'b1;
      end
    end else if (wr.en) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_index <= boxes.first_of_set ? '0 : next_index;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fin_go) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_accepted   <= fits;
      out_table_full <= !done.hit && !fits;
      out_index      <= item_index;
    end
  end

  assign results.valid      = out_vld;
  assign results.accepted   = out_accepted;
  assign results.table_full = out_table_full;
  assign results.box_index  = out_index;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BOXES))
    else $error("fill count beyond table size");

  a_exit_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[MAX_BOXES].vld |-> state == ST_SCAN)
    else $error("token left chain outside scan");

  a_take_launch: assert property (@(posedge clk) disable iff (rst)
    take |=> chain[0].vld && state == ST_SCAN)
    else $error("accepted box not launched");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> count == $past(count) + 1'b1)
    else $error("append did not advance fill count");

  a_verdict_excl: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(out_accepted && out_table_full))
    else $error("accepted and table_full both set");
`endif

endmodule
